### hdl/tsge_pkg.sv
// Shared types, action codes and timing constants for the touch strip gesture engine.
// No dependencies.
package tsge_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [2:0] ACT_HOLD_SHIFT = 3'd0;
  localparam logic [2:0] ACT_REL_SHIFT  = 3'd1;
  localparam logic [2:0] ACT_HOLD_ALT   = 3'd2;
  localparam logic [2:0] ACT_REL_ALT    = 3'd3;
  localparam logic [2:0] ACT_WHEEL      = 3'd4;
  localparam logic [2:0] ACT_APP        = 3'd5;
  localparam logic [2:0] ACT_DESK       = 3'd6;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_PAN  = 2'd1;
  localparam logic [1:0] MODE_APP  = 2'd2;
  localparam logic [1:0] MODE_DESK = 2'd3;

  localparam logic       REG_ENABLE = 1'b0;
  localparam logic       REG_MODE   = 1'b1;

  localparam logic [1:0] NO_SEG  = 2'd3;
  localparam logic [1:0] MAX_RES = 2'd3;

  localparam int ACT_DELAY_MS  = 20;
  localparam int APP_DELAY_MS  = 90;
  localparam int SEEK_MS       = 500;
  localparam int APP_HOLD_MS   = 400;
  localparam int DESK_HOLD_MS  = 1200;
  localparam int GUARD_MS      = 50;
  localparam int REL_MS        = 35;
  localparam int PAN_MS        = 12;
  localparam int APP_STEP_MS   = 55;
  localparam int APP_DIST      = 160;
  localparam int DESK_DIST     = 256;
  localparam int FINAL_DIST    = 96;
  localparam int DEADZONE      = 64;
  localparam int EDGE_HI       = 704;
  localparam int RECIP_160     = 6554;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][2:0] act;
    logic [2:0][3:0] amt;
  } bundle_t;

  function automatic bundle_t push_res(bundle_t b, logic [2:0] a, logic [3:0] m);
    bundle_t r;
    r = b;
    if (r.cnt != MAX_RES) begin
      r.act[r.cnt] = a;
      r.amt[r.cnt] = m;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

### hdl/tsge_front.sv
// Front end: accepts ticks, computes centroid and session state, builds result bundles.
// Depends on tsge_pkg.
module tsge_front #(
  parameter int TW = tsge_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_wdata,
  output logic                push,
  input  logic                full,
  output tsge_pkg::bundle_t   bundle
);

  typedef enum logic [1:0] {IDLE, CENT, DIVP, COMMIT} fstate_t;

  typedef struct packed {
    logic              touching;
    logic              gesture_active;
    logic              seek_mode;
    logic              release_pending;
    logic              shift_primed;
    logic              shift_held;
    logic              alt_held;
    logic              mods_drop;
    logic [1:0]        segment_sel;
    logic [2:0]        finger_count;
    logic [TW-1:0]     start_time;
    logic [TW-1:0]     last_touch_time;
    logic [TW-1:0]     last_pan_time;
    logic [TW-1:0]     last_step_time;
    logic [TW-1:0]     edge_start_time;
    logic [TW-1:0]     guard_until_time;
    logic [15:0]       anchor_pos;
    logic [9:0]        current_pos;
    logic [15:0]       steps_done;
    logic signed [1:0] edge_dir;
  } st_t;

  typedef struct packed {
    st_t               s;
    tsge_pkg::bundle_t b;
  } work_t;

  fstate_t       fs;
  st_t           st;
  st_t           st_next;
  logic          bar_enable;
  logic [1:0]    gesture_mode;
  logic [TW-1:0] now_r;
  logic [5:0]    pads_r;
  logic [1:0]    seg_r;
  logic [2:0]    cnt_r;
  logic [9:0]    pos_r;
  logic          pv_r;
  logic [15:0]   disp_r;
  logic [16:0]   dist_r;
  logic [7:0]    q0_r;

  function automatic logic [TW-1:0] tdiff(logic [TW-1:0] a, logic [TW-1:0] b);
    return a - b;
  endfunction

  function automatic st_t clr(st_t s);
    st_t r;
    r = '0;
    r.shift_held  = s.shift_held;
    r.alt_held    = s.alt_held;
    r.mods_drop   = s.mods_drop;
    r.segment_sel = tsge_pkg::NO_SEG;
    return r;
  endfunction

  function automatic work_t rel(work_t w);
    work_t r;
    r = w;
    if (r.s.shift_held) begin
      r.b = tsge_pkg::push_res(r.b, tsge_pkg::ACT_REL_SHIFT, 4'd0);
      r.s.shift_held = 1'b0;
    end
    if (r.s.alt_held) begin
      r.b = tsge_pkg::push_res(r.b, tsge_pkg::ACT_REL_ALT, 4'd0);
      r.s.alt_held = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t dostep(work_t w, logic [2:0] kind, logic signed [1:0] d);
    work_t r;
    r = w;
    if (kind == tsge_pkg::ACT_APP && !r.s.alt_held) begin
      r.b = tsge_pkg::push_res(r.b, tsge_pkg::ACT_HOLD_ALT, 4'd0);
      r.s.alt_held = 1'b1;
    end
    r.b = tsge_pkg::push_res(r.b, kind, {{2{d[1]}}, d});
    r.s.steps_done = r.s.steps_done + {{14{d[1]}}, d};
    return r;
  endfunction

  function automatic work_t erep(work_t w, logic [TW-1:0] now, logic [10:0] hold,
                                 logic [9:0] ivl, logic [8:0] dst, logic [2:0] kind,
                                 logic signed [1:0] edc);
    work_t r;
    r = w;
    if (edc == 2'sd0) begin
      r.s.edge_start_time = '0;
      r.s.edge_dir = 2'sd0;
    end else if (r.s.edge_dir != edc) begin
      r.s.edge_dir = edc;
      r.s.edge_start_time = now;
    end else if (tdiff(now, r.s.edge_start_time) >= TW'(hold) &&
                 tdiff(now, r.s.last_step_time) >= TW'(ivl)) begin
      r.s.last_step_time = now;
      r = dostep(r, kind, edc);
      r.s.anchor_pos = edc[1] ? r.s.anchor_pos + 16'(dst) : r.s.anchor_pos - 16'(dst);
    end
    return r;
  endfunction

  function automatic logic [9:0] centroid(logic [2:0] k, logic [2:0] n);
    logic [9:0] p;
    p = '0;
    case (n)
      3'd1: p = {k[1:0], 8'd0};
      3'd2: p = {k, 7'd0};
      3'd3: begin
        case (k)
          3'd3:    p = 10'd256;
          3'd4:    p = 10'd341;
          3'd5:    p = 10'd426;
          3'd6:    p = 10'd512;
          default: p = '0;
        endcase
      end
      3'd4: p = {1'b0, k, 6'd0};
      default: p = '0;
    endcase
    return p;
  endfunction

  logic [2:0] l_cnt, r_cnt, n_all, cnt_c, k_c;
  logic [3:0] sidx;
  logic [1:0] selseg, seg_c;
  logic [3:0] nib;

  always_comb begin
    l_cnt = 3'(pads_r[0]) + 3'(pads_r[1]) + 3'(pads_r[2]);
    r_cnt = 3'(pads_r[3]) + 3'(pads_r[4]) + 3'(pads_r[5]);
    n_all = l_cnt + r_cnt;
    sidx  = 4'd0;
    for (int i = 0; i < 6; i++) begin
      if (pads_r[i]) sidx = sidx + 4'(i);
    end
    if (l_cnt == 3'd0 && r_cnt == 3'd0) selseg = tsge_pkg::NO_SEG;
    else if (l_cnt > r_cnt) selseg = 2'd0;
    else if (r_cnt > l_cnt) selseg = 2'd1;
    else selseg = (5'(sidx) < 5'(n_all) * 5'd3) ? 2'd0 : 2'd1;
    seg_c = st.touching ? st.segment_sel : selseg;
    nib = (seg_c == 2'd0) ? pads_r[3:0] : pads_r[5:2];
    cnt_c = 3'(nib[0]) + 3'(nib[1]) + 3'(nib[2]) + 3'(nib[3]);
    k_c = (nib[1] ? 3'd1 : 3'd0) + (nib[2] ? 3'd2 : 3'd0) + (nib[3] ? 3'd3 : 3'd0);
  end

  logic [15:0] disp_c;
  logic [16:0] dist_c;
  logic [29:0] prod_c;

  always_comb begin
    disp_c = {6'd0, (pv_r ? pos_r : st.current_pos)} - st.anchor_pos;
    dist_c = disp_c[15] ? 17'd0 - {disp_c[15], disp_c} : {1'b0, disp_c};
    prod_c = 30'(dist_c) * 30'(tsge_pkg::RECIP_160);
  end

  work_t             w;
  logic              dneg, dpos;
  logic [7:0]        q;
  logic [16:0]       q17, tgt, done, d256;
  logic [15:0]       q160;
  logic [9:0]        tsp;
  logic [2:0]        speed;
  logic signed [1:0] edc, dirv;
  logic              blk, act_now;

  always_comb begin
    dneg = disp_r[15];
    dpos = !disp_r[15] && disp_r != 16'd0;
    q160 = 16'(q0_r) * 16'(tsge_pkg::APP_DIST);
    q = (17'(q160) > dist_r) ? q0_r - 8'd1 : q0_r;
    q17 = {9'd0, q};
    d256 = {8'd0, dist_r[16:8]};
    done = {st.steps_done[15], st.steps_done};
    tsp = 10'((dist_r - 17'(tsge_pkg::DEADZONE)) >> 7);
    speed = (tsp >= 10'd5) ? 3'd6 : 3'(tsp + 10'd1);
    if (pos_r <= 10'(tsge_pkg::DEADZONE)) edc = -2'sd1;
    else if (pos_r >= 10'(tsge_pkg::EDGE_HI)) edc = 2'sd1;
    else edc = 2'sd0;
    tgt = '0;
    dirv = 2'sd0;
    blk = 1'b0;
    act_now = 1'b0;
    w.s = st;
    w.b = '0;
    if (w.s.mods_drop) begin
      w = rel(w);
      w.s.mods_drop = 1'b0;
    end
    if (!bar_enable || gesture_mode == tsge_pkg::MODE_OFF) begin
      w.s = clr(w.s);
      w = rel(w);
    end else if (!pv_r) begin
      if (w.s.touching) begin
        if (!w.s.release_pending) begin
          w.s.release_pending = 1'b1;
          w.s.last_touch_time = now_r;
        end else if (tdiff(now_r, w.s.last_touch_time) >=
                     ((gesture_mode >= tsge_pkg::MODE_APP) ? TW'(tsge_pkg::APP_DELAY_MS)
                                                         : TW'(tsge_pkg::REL_MS))) begin
          if (gesture_mode == tsge_pkg::MODE_DESK && w.s.gesture_active && !w.s.seek_mode &&
              dist_r >= 17'(tsge_pkg::FINAL_DIST)) begin
            w.b = tsge_pkg::push_res(w.b, tsge_pkg::ACT_DESK, dpos ? 4'sd1 : -4'sd1);
          end
          w.s = clr(w.s);
          w = rel(w);
        end
      end
    end else begin
      w.s.release_pending = 1'b0;
      w.s.last_touch_time = now_r;
      w.s.current_pos = pos_r;
      if (gesture_mode == tsge_pkg::MODE_APP) begin
        if (w.s.gesture_active && w.s.finger_count > cnt_r && cnt_r == 3'd1)
          w.s.guard_until_time = now_r + TW'(tsge_pkg::GUARD_MS);
        else if (cnt_r > 3'd1)
          w.s.guard_until_time = '0;
      end
      if (!w.s.touching) begin
        w.s = clr(w.s);
        w.s.touching = 1'b1;
        w.s.segment_sel = seg_r;
        w.s.finger_count = cnt_r;
        w.s.start_time = now_r;
        w.s.last_touch_time = now_r;
        w.s.last_pan_time = now_r;
        w.s.last_step_time = now_r;
        w.s.anchor_pos = {6'd0, pos_r};
        w.s.current_pos = pos_r;
      end else begin
        w.s.finger_count = cnt_r;
        act_now = w.s.gesture_active;
        if (!w.s.gesture_active &&
            tdiff(now_r, w.s.start_time) >=
            ((gesture_mode == tsge_pkg::MODE_APP) ? TW'(tsge_pkg::APP_DELAY_MS)
                                                 : TW'(tsge_pkg::ACT_DELAY_MS))) begin
          w.s.gesture_active = 1'b1;
          act_now = 1'b1;
        end
        if (act_now) begin
          case (gesture_mode)
            tsge_pkg::MODE_PAN: begin
              if (tdiff(now_r, w.s.last_pan_time) >= TW'(tsge_pkg::PAN_MS)) begin
                w.s.last_pan_time = now_r;
                if (dist_r > 17'(tsge_pkg::DEADZONE)) begin
                  if (!w.s.shift_held) begin
                    w.b = tsge_pkg::push_res(w.b, tsge_pkg::ACT_HOLD_SHIFT, 4'd0);
                    w.s.shift_held = 1'b1;
                  end
                  if (!w.s.shift_primed) begin
                    w.s.shift_primed = 1'b1;
                  end else begin
                    w.b = tsge_pkg::push_res(w.b, tsge_pkg::ACT_WHEEL,
                                             dpos ? 4'd0 - {1'b0, speed} : {1'b0, speed});
                  end
                end
              end
            end
            tsge_pkg::MODE_APP: begin
              if (!(now_r < w.s.guard_until_time)) begin
                tgt = dneg ? 17'd0 - q17 : q17;
                if (tgt == done) begin
                  w = erep(w, now_r, 11'(tsge_pkg::APP_HOLD_MS), 10'(tsge_pkg::APP_STEP_MS),
                           9'(tsge_pkg::APP_DIST), tsge_pkg::ACT_APP, edc);
                end else if (tdiff(now_r, w.s.last_step_time) >= TW'(tsge_pkg::APP_STEP_MS)) begin
                  w.s.last_step_time = now_r;
                  w.s.edge_start_time = '0;
                  w.s.edge_dir = 2'sd0;
                  dirv = ($signed(tgt) > $signed(done)) ? 2'sd1 : -2'sd1;
                  w = dostep(w, tsge_pkg::ACT_APP, dirv);
                end
              end
            end
            tsge_pkg::MODE_DESK: begin
              if (!w.s.seek_mode) begin
                if (tdiff(now_r, w.s.start_time) >= TW'(tsge_pkg::SEEK_MS)) begin
                  w.s.seek_mode = 1'b1;
                  w.s.anchor_pos = {6'd0, pos_r};
                  w.s.steps_done = '0;
                  w.s.edge_start_time = '0;
                  w.s.edge_dir = 2'sd0;
                  w.s.last_step_time = now_r - TW'(tsge_pkg::SEEK_MS);
                end
              end else begin
                tgt = dneg ? 17'd0 - d256 : d256;
                if (tgt == done) begin
                  w = erep(w, now_r, 11'(tsge_pkg::DESK_HOLD_MS), 10'(tsge_pkg::SEEK_MS),
                           9'(tsge_pkg::DESK_DIST), tsge_pkg::ACT_DESK, edc);
                end else begin
                  dirv = ($signed(tgt) > $signed(done)) ? 2'sd1 : -2'sd1;
                  if (edc == 2'sd0) begin
                    w.s.edge_start_time = '0;
                    w.s.edge_dir = 2'sd0;
                  end else if (dirv == edc) begin
                    if (w.s.edge_dir != edc) begin
                      w.s.edge_dir = edc;
                      w.s.edge_start_time = now_r;
                    end else if (tdiff(now_r, w.s.edge_start_time) <
                                 TW'(tsge_pkg::DESK_HOLD_MS)) begin
                      blk = 1'b1;
                    end
                  end
                  if (!blk && tdiff(now_r, w.s.last_step_time) >= TW'(tsge_pkg::SEEK_MS)) begin
                    w.s.last_step_time = now_r;
                    w = dostep(w, tsge_pkg::ACT_DESK, dirv);
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    st_next = st;
    if (fs == COMMIT && (w.b.cnt == 2'd0 || !full)) st_next = w.s;
    if (cfg_we &&
        ((cfg_index == tsge_pkg::REG_ENABLE && cfg_wdata[0] != bar_enable) ||
         (cfg_index == tsge_pkg::REG_MODE && cfg_wdata != gesture_mode))) begin
      st_next = clr(st_next);
      st_next.mods_drop = 1'b1;
    end
  end

  assign s_tready = (fs == IDLE);
  assign bundle   = w.b;
  assign push     = (fs == COMMIT) && (w.b.cnt != 2'd0) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= IDLE;
      st <= clr('0);
      bar_enable <= 1'b1;
      gesture_mode <= tsge_pkg::MODE_PAN;
    end else begin
      st <= st_next;
      case (fs)
        IDLE: begin
          if (s_tvalid) begin
            now_r <= s_tdata[TW-1:0];
            pads_r <= s_tdata[37:32];
            fs <= CENT;
          end
        end
        CENT: begin
          seg_r <= seg_c;
          cnt_r <= cnt_c;
          pos_r <= centroid(k_c, cnt_c);
          pv_r <= (seg_c != tsge_pkg::NO_SEG) && (cnt_c != 3'd0);
          fs <= DIVP;
        end
        DIVP: begin
          disp_r <= disp_c;
          dist_r <= dist_c;
          q0_r <= prod_c[27:20];
          fs <= COMMIT;
        end
        COMMIT: begin
          if (w.b.cnt == 2'd0 || !full) begin
            fs <= IDLE;
          end
        end
        default: fs <= IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          tsge_pkg::REG_ENABLE: bar_enable <= cfg_wdata[0];
          tsge_pkg::REG_MODE: gesture_mode <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

### hdl/tsge_queue.sv
// Two-entry bundle queue between the front end and the output sequencer.
// Depends on tsge_pkg.
module tsge_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsge_pkg::bundle_t din,
  output logic              full,
  input  logic              pop,
  output tsge_pkg::bundle_t dout,
  output logic              empty
);

  tsge_pkg::bundle_t mem [2];
  logic              wp, rp;
  logic [1:0]        count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wp] <= din;
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/tsge_back.sv
// Output sequencer: unpacks queued bundles into single result transfers.
// Depends on tsge_pkg.
module tsge_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  tsge_pkg::bundle_t head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);

  logic [1:0] idx;
  logic       load, fin;

  assign load = !empty && (!m_tvalid || m_tready);
  assign fin  = (idx == head.cnt - 2'd1);
  assign pop  = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, head.amt[idx], head.act[idx]};
        m_tlast <= fin;
        idx <= fin ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hdl/touch_strip_gesture_engine.sv
// Touch strip gesture engine top level: front end, bundle queue and output sequencer.
// A tick's results enter the queue in the commit state; the output sequencer then registers each result.
// A new tick is accepted only in idle, after the front end sequencer (capture, centroid, divide prep,
// commit) has finished the last one; commit holds while the queue is full and the bundle has results.
// Reset: synchronous rst clears session, bar_enable=1, gesture_mode=pan, queue empty.
// Depends on tsge_pkg, tsge_front, tsge_queue, tsge_back.
module touch_strip_gesture_engine #(
  parameter int TIME_WIDTH = tsge_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // now_ms[31:0], pad_states[37:32], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // action[2:0], amount[6:3], zero pad
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_wdata
);

  logic              q_push, q_full, q_pop, q_empty;
  tsge_pkg::bundle_t q_din, q_dout;

  tsge_front #(.TW(TIME_WIDTH)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(q_push), .full(q_full), .bundle(q_din)
  );

  tsge_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  tsge_back u_back (
    .clk(clk), .rst(rst), .empty(q_empty), .head(q_dout), .pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty queue");
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("tick accepted while busy");

endmodule
